// ----- src/one_wire_slave_slot_engine_macros.svh -----
// Assertion macros shared by the checking code of the slot engine.
// In synthesis the macros expand to nothing.
`ifndef ONE_WIRE_SLAVE_SLOT_ENGINE_MACROS_SVH
`define ONE_WIRE_SLAVE_SLOT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define OWSSE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot engine check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define OWSSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot engine check failed");
`else
`define OWSSE_ASSERT_NOW(label, clk, rst, ante, cons)
`define OWSSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/owsse_pkg.sv -----
package owsse_pkg;

  // Event codes carried in the op field.
  localparam logic [1:0] OP_SLOT  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // Function command bytes.
  localparam logic [7:0] CMD_READ_ROM = 8'h33;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  // The ROM code is eight bytes long.
  localparam int ROM_BYTES = 8;

  // Default scratchpad size.
  localparam int SCRATCH_BYTES_DEFAULT = 9;

  // One input transaction.
  typedef struct packed {
    logic [1:0] op;
    logic       line_bit;
    logic [3:0] pad_index;
    logic [7:0] pad_value;
  } owsse_in_t;

  // One result transaction.
  typedef struct packed {
    logic drive_zero;
    logic presence_pulse;
    logic start_conversion;
    logic answering;
  } owsse_out_t;

endpackage

// ----- src/owsse_in_stage.sv -----
module owsse_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  owsse_pkg::owsse_in_t in_data,
  input  logic                 advance,
  output logic                 held,
  output owsse_pkg::owsse_in_t item
);

  logic accept;

  // The register only refuses a transaction when it is full and cannot move on.
  assign in_stall = held && !advance;
  assign accept   = in_valid && !in_stall;

  // Occupancy flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

endmodule

// ----- src/owsse_slot_logic.sv -----
module owsse_slot_logic #(
  parameter int SCRATCH_BYTES = owsse_pkg::SCRATCH_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [63:0]           cfg_data,
  input  logic                  advance,
  input  owsse_pkg::owsse_in_t  item,
  output owsse_pkg::owsse_out_t result
);

  localparam int BUF_BYTES = (owsse_pkg::ROM_BYTES > SCRATCH_BYTES) ?
                             owsse_pkg::ROM_BYTES : SCRATCH_BYTES;
  localparam int BUF_AW    = $clog2(BUF_BYTES);

  logic [63:0] rom_code;
  logic        answer_mode;
  logic [2:0]  bit_count;
  logic [3:0]  byte_index;
  logic [3:0]  answer_length;
  logic [7:0]  shift_byte;
  logic [7:0]  answer_buffer [BUF_BYTES];
  logic [7:0]  scratchpad [SCRATCH_BYTES];

  logic        answer_mode_next;
  logic [2:0]  bit_count_next;
  logic [3:0]  byte_index_next;
  logic [3:0]  answer_length_next;
  logic [7:0]  shift_byte_next;
  logic        load_rom;
  logic        load_pad;
  logic        byte_done;
  logic [3:0]  byte_step;
  logic [7:0]  shifted_in;

  assign byte_done  = (bit_count == 3'd7);
  assign byte_step  = byte_index + 4'd1;
  assign shifted_in = {item.line_bit, shift_byte[7:1]};

  // Next state and result for the item held in the input register.
  always_comb begin
    answer_mode_next   = answer_mode;
    bit_count_next     = bit_count;
    byte_index_next    = byte_index;
    answer_length_next = answer_length;
    shift_byte_next    = shift_byte;
    load_rom           = 1'b0;
    load_pad           = 1'b0;
    result             = '0;
    case (item.op)
      owsse_pkg::OP_SLOT: begin
        bit_count_next = bit_count + 3'd1;
        if (answer_mode) begin
          // Send the low bit; a zero is answered by holding the line low.
          result.drive_zero = !shift_byte[0];
          shift_byte_next   = {1'b0, shift_byte[7:1]};
          if (byte_done) begin
            byte_index_next = byte_step;
            if (byte_step >= answer_length) begin
              answer_mode_next = 1'b0;
            end else begin
              shift_byte_next = answer_buffer[byte_step[BUF_AW-1:0]];
            end
          end
        end else begin
          // Receive a command bit, LSB first, and decode a complete byte.
          shift_byte_next = shifted_in;
          if (byte_done) begin
            case (shifted_in)
              owsse_pkg::CMD_READ_ROM: begin
                load_rom           = 1'b1;
                answer_length_next = 4'(owsse_pkg::ROM_BYTES);
                byte_index_next    = '0;
                shift_byte_next    = rom_code[7:0];
                answer_mode_next   = 1'b1;
              end
              owsse_pkg::CMD_CONVERT: begin
                result.start_conversion = 1'b1;
              end
              owsse_pkg::CMD_READ_PAD: begin
                load_pad           = 1'b1;
                answer_length_next = 4'(SCRATCH_BYTES);
                byte_index_next    = '0;
                shift_byte_next    = scratchpad[0];
                answer_mode_next   = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      owsse_pkg::OP_RESET: begin
        result.presence_pulse = 1'b1;
        answer_mode_next      = 1'b0;
        bit_count_next        = '0;
      end
      default: begin
      end
    endcase
    result.answering = answer_mode_next;
  end

  // ROM code register; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_code <= '0;
    end else if (cfg_we) begin
      rom_code <= cfg_data;
    end
  end

  // Control and shift state.
  always_ff @(posedge clk) begin
    if (rst) begin
      answer_mode   <= 1'b0;
      bit_count     <= '0;
      byte_index    <= '0;
      answer_length <= '0;
      shift_byte    <= '0;
    end else if (advance) begin
      answer_mode   <= answer_mode_next;
      bit_count     <= bit_count_next;
      byte_index    <= byte_index_next;
      answer_length <= answer_length_next;
      shift_byte    <= shift_byte_next;
    end
  end

  // Scratchpad bytes, each with its own write decode.
  for (genvar p = 0; p < SCRATCH_BYTES; p++) begin : g_pad
    always_ff @(posedge clk) begin
      if (rst) begin
        scratchpad[p] <= '0;
      end else if (advance && item.op == owsse_pkg::OP_LOAD &&
                   item.pad_index == 4'(p)) begin
        scratchpad[p] <= item.pad_value;
      end
    end
  end

  // Answer buffer: the whole snapshot is taken in the decoding cycle.
  for (genvar b = 0; b < BUF_BYTES; b++) begin : g_buf
    always_ff @(posedge clk) begin
      if (advance) begin
        if (load_rom && b < owsse_pkg::ROM_BYTES) begin
          answer_buffer[b] <= rom_code[8*(b % owsse_pkg::ROM_BYTES) +: 8];
        end else if (load_pad && b < SCRATCH_BYTES) begin
          answer_buffer[b] <= scratchpad[b % SCRATCH_BYTES];
        end
      end
    end
  end

endmodule

// ----- src/owsse_out_stage.sv -----
module owsse_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  held,
  input  owsse_pkg::owsse_out_t result,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_stall,
  output owsse_pkg::owsse_out_t out_data
);

  // An item moves on when the result register is empty or being emptied.
  assign advance = held && (!out_valid || !out_stall);

  // Occupancy flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result capture.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// ----- src/one_wire_slave_slot_engine.sv -----
// Slot-level 1-Wire slave. Each input transaction is a data time slot, a reset
// pulse or a scratchpad byte load, and each gives exactly one result
// transaction. The block takes one transaction per clock cycle unless the input
// side stalls; an accepted transaction waits in the input register, and the
// state update writes its result into the result register. Back-pressure on
// the result side reaches the input side only once both registers are full.
// The ROM code register and the scratchpad clear to zero at reset, so the
// block is ready once reset ends; write the ROM code only while idle.
`include "one_wire_slave_slot_engine_macros.svh"

module one_wire_slave_slot_engine #(
  parameter int SCRATCH_BYTES = owsse_pkg::SCRATCH_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [63:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  owsse_pkg::owsse_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output owsse_pkg::owsse_out_t out_data
);

  logic                  held;
  logic                  advance;
  owsse_pkg::owsse_in_t  item;
  owsse_pkg::owsse_out_t result;

  // Input register.
  owsse_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .held     (held),
    .item     (item)
  );

  // State update and result decode.
  owsse_slot_logic #(
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_logic (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .advance  (advance),
    .item     (item),
    .result   (result)
  );

  // Result register.
  owsse_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .held      (held),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The input side stalls only when both registers are occupied.
  `OWSSE_ASSERT_NOW(a_stall_full, clk, rst, in_stall, held && out_valid && out_stall)
  // A reset pulse gives a presence result in command mode.
  `OWSSE_ASSERT_NEXT(a_reset_presence, clk, rst, advance && item.op == owsse_pkg::OP_RESET, out_valid && out_data.presence_pulse && !out_data.answering)
  // A convert strobe is only decoded in command mode and leaves it unchanged.
  `OWSSE_ASSERT_NOW(a_convert_cmd, clk, rst, out_valid && out_data.start_conversion, !out_data.answering && !out_data.drive_zero)
  // Presence never coincides with an answered bit.
  `OWSSE_ASSERT_NOW(a_presence_alone, clk, rst, out_valid && out_data.presence_pulse, !out_data.drive_zero && !out_data.start_conversion)

endmodule

// ----- dv/owsse_response_checker.sv -----
// Watches both channels of the slot engine, predicts the result of every
// accepted input transaction and compares it with the results that leave
// the block, oldest first.
module owsse_response_checker
  import owsse_pkg::*;
#(
  parameter int SCRATCH_BYTES = SCRATCH_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  owsse_in_t   in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  owsse_out_t  out_data,
  output int          mismatch_count,
  output int          outstanding,
  output int          responses_checked,
  output int          rom_reads,
  output int          pad_reads,
  output int          conversions,
  output int          presences
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted device state, held at the widths of the block.
  logic [63:0] rom_code;
  logic        answer_mode;
  logic [2:0]  bit_count;
  logic [3:0]  byte_index;
  logic [3:0]  answer_length;
  logic [7:0]  shift_byte;
  logic [7:0]  answer_buffer [16];
  logic [7:0]  scratchpad [16];

  owsse_out_t expected_responses [$];
  owsse_out_t predicted;
  owsse_out_t oldest;

  // Enter answer mode with the first buffered byte ready to shift out.
  task automatic start_answer(input int length);
    answer_length = 4'(length);
    byte_index    = 4'd0;
    shift_byte    = answer_buffer[0];
    answer_mode   = 1'b1;
  endtask

  // Advance the predicted device by one event and work out its result.
  task automatic compute_slot_response(input owsse_in_t item, output owsse_out_t res);
    int i;
    res = '0;
    case (item.op)
      OP_SLOT: begin
        if (answer_mode) begin
          // Answer mode: send the next bit, pulling the line low for a zero.
          res.drive_zero = ~shift_byte[0];
          shift_byte = shift_byte >> 1;
          bit_count  = bit_count + 3'd1;
          if (bit_count == 3'd0) begin
            byte_index = byte_index + 4'd1;
            if (byte_index >= answer_length) begin
              answer_mode = 1'b0;
            end else begin
              shift_byte = answer_buffer[byte_index];
            end
          end
        end else begin
          // Command mode: shift the sampled bit in from the top, LSB first.
          shift_byte = {item.line_bit, shift_byte[7:1]};
          bit_count  = bit_count + 3'd1;
          if (bit_count == 3'd0) begin
            if (shift_byte == CMD_READ_ROM) begin
              for (i = 0; i < ROM_BYTES; i++) begin
                answer_buffer[i] = rom_code[8*i +: 8];
              end
              start_answer(ROM_BYTES);
              rom_reads++;
            end else if (shift_byte == CMD_CONVERT) begin
              res.start_conversion = 1'b1;
              conversions++;
            end else if (shift_byte == CMD_READ_PAD) begin
              for (i = 0; i < SCRATCH_BYTES && i < 16; i++) begin
                answer_buffer[i] = scratchpad[i];
              end
              start_answer(SCRATCH_BYTES);
              pad_reads++;
            end
          end
        end
      end
      OP_RESET: begin
        // A reset pulse abandons any answer and restarts the bit count.
        res.presence_pulse = 1'b1;
        answer_mode = 1'b0;
        bit_count   = 3'd0;
        presences++;
      end
      OP_LOAD: begin
        if (item.pad_index < SCRATCH_BYTES) begin
          scratchpad[item.pad_index] = item.pad_value;
        end
      end
      default: begin
      end
    endcase
    res.answering = answer_mode;
  endtask

  // Report one field that differs from its prediction.
  task automatic check_field(input string name, input logic expected, input logic actual);
    if (actual !== expected) begin
      $display("%0t ns: result %0d field %s mismatch, expected %b, actual %b",
               $time, responses_checked, name, expected, actual);
      mismatch_count++;
    end
  endtask

  // Sample both channels at the rising edge; results are checked before the
  // input transaction of the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      rom_code          = '0;
      answer_mode       = 1'b0;
      bit_count         = '0;
      byte_index        = '0;
      answer_length     = '0;
      shift_byte        = '0;
      mismatch_count    = 0;
      responses_checked = 0;
      rom_reads         = 0;
      pad_reads         = 0;
      conversions       = 0;
      presences         = 0;
      for (int i = 0; i < 16; i++) begin
        answer_buffer[i] = '0;
        scratchpad[i]    = '0;
      end
      expected_responses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          $display("%0t ns: result with no transaction pending, expected none, actual %b",
                   $time, out_data);
          mismatch_count++;
        end else begin
          oldest = expected_responses.pop_front();
          check_field("drive_zero", oldest.drive_zero, out_data.drive_zero);
          check_field("presence_pulse", oldest.presence_pulse, out_data.presence_pulse);
          check_field("start_conversion", oldest.start_conversion,
                      out_data.start_conversion);
          check_field("answering", oldest.answering, out_data.answering);
        end
        responses_checked++;
      end
      if (in_valid && !in_stall) begin
        compute_slot_response(in_data, predicted);
        expected_responses.push_back(predicted);
      end
      if (cfg_we) begin
        rom_code = cfg_data;
      end
    end
    outstanding = expected_responses.size();
  end

endmodule

// ----- dv/tb_one_wire_slave_slot_engine.sv -----
// Stimulus and verdict for the slot engine; all checking sits in the
// response checker beside the block.
module tb_one_wire_slave_slot_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import owsse_pkg::*;

  // The op value that the block has no use for.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int PAD_BYTES    = SCRATCH_BYTES_DEFAULT;
  localparam int TARGET_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  owsse_in_t   in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  owsse_out_t  out_data;

  int mismatch_count;
  int outstanding;
  int responses_checked;
  int rom_reads;
  int pad_reads;
  int conversions;
  int presences;

  int items_sent = 0;
  int cycle_count = 0;
  int gap_chance = 0;
  bit quiet_tail = 1'b0;
  bit hold_req = 1'b0;

  one_wire_slave_slot_engine #(
    .SCRATCH_BYTES(PAD_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  owsse_response_checker #(
    .SCRATCH_BYTES(PAD_BYTES)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding),
    .responses_checked(responses_checked),
    .rom_reads        (rom_reads),
    .pad_reads        (pad_reads),
    .conversions      (conversions),
    .presences        (presences)
  );

  // Free-running clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a run that outlives the limit has hung.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t ns: timeout after %0d cycles, %0d results still awaited",
             $time, cycle_count, outstanding);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall bursts, quiet runs, and a long hold-off on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_req = 1'b0;
      end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b0;
        end
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Build an event with random content in the fields it does not use.
  function automatic owsse_in_t make_item(input logic [1:0] op, input logic line);
    owsse_in_t item;
    item.op        = op;
    item.line_bit  = line;
    item.pad_index = 4'($urandom_range(0, 15));
    item.pad_value = 8'($urandom_range(0, 255));
    return item;
  endfunction

  // Offer one transaction and hold it until the block accepts it.
  task automatic send_item(input owsse_in_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!(item.op == OP_UNUSED || (item.op == OP_LOAD && item.pad_index >= PAD_BYTES))) begin
      items_sent++;
    end
  endtask

  // Leave the input idle for a number of cycles.
  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Send an event and perhaps idle afterwards, as the current stretch allows.
  task automatic send_paced(input owsse_in_t item);
    send_item(item);
    if (!quiet_tail && gap_chance != 0 && $urandom_range(1, gap_chance) == 1) begin
      sender_gap($urandom_range(1, 12));
    end
  endtask

  task automatic send_command(input logic [7:0] cmd);
    for (int i = 0; i < 8; i++) begin
      send_paced(make_item(OP_SLOT, cmd[i]));
    end
  endtask

  task automatic send_slots(input int n);
    repeat (n) send_paced(make_item(OP_SLOT, 1'($urandom_range(0, 1))));
  endtask

  task automatic send_load(input logic [3:0] idx, input logic [7:0] val);
    owsse_in_t item;
    item = make_item(OP_LOAD, 1'($urandom_range(0, 1)));
    item.pad_index = idx;
    item.pad_value = val;
    send_paced(item);
  endtask

  // Stop offering and wait until every predicted result has arrived.
  task automatic drain();
    do begin
      @(negedge clk);
      in_valid <= 1'b0;
    end while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the ROM code while the block is idle.
  task automatic write_rom(input logic [63:0] value);
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random traffic, mostly well-formed command sequences with noise between.
  task automatic run_random(input int target_total, input bit ask_hold, input bit mid_drain);
    int kind;
    int answer_bits;
    int start_count;
    logic [7:0] cmd;
    start_count = items_sent;
    while (items_sent < target_total) begin
      gap_chance = ($urandom_range(0, 3) == 0) ? 0 : 4;
      if (ask_hold && items_sent - start_count > 40) begin
        hold_req = 1'b1;
        ask_hold = 1'b0;
      end
      if (mid_drain && items_sent - start_count > 100) begin
        drain();
        mid_drain = 1'b0;
      end
      if (target_total == TARGET_ITEMS && target_total - items_sent < 100) begin
        quiet_tail = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        send_paced(make_item(OP_RESET, 1'($urandom_range(0, 1))));
      end else if (kind < 55) begin
        // A command, after a reset half of the time, followed by its answer.
        if ($urandom_range(0, 1) == 1) begin
          send_paced(make_item(OP_RESET, 1'($urandom_range(0, 1))));
        end
        case ($urandom_range(0, 9))
          0, 1, 2: cmd = CMD_READ_ROM;
          3, 4, 5: cmd = CMD_READ_PAD;
          6, 7:    cmd = CMD_CONVERT;
          default: cmd = 8'($urandom_range(0, 255));
        endcase
        send_command(cmd);
        if (cmd == CMD_READ_ROM) begin
          answer_bits = 8 * ROM_BYTES;
        end else if (cmd == CMD_READ_PAD) begin
          answer_bits = 8 * PAD_BYTES;
        end else begin
          answer_bits = 0;
        end
        if (answer_bits != 0 && $urandom_range(0, 5) == 0) begin
          // The master cuts the answer short with a reset.
          send_slots($urandom_range(1, answer_bits - 1));
          send_paced(make_item(OP_RESET, 1'($urandom_range(0, 1))));
        end else begin
          send_slots(answer_bits);
        end
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 4) == 0) begin
            send_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
          end else begin
            send_load(4'($urandom_range(0, PAD_BYTES - 1)), 8'($urandom_range(0, 255)));
          end
        end
      end else if (kind < 85) begin
        send_paced(make_item(OP_UNUSED, 1'($urandom_range(0, 1))));
      end else begin
        // Stray slots that knock the command framing out of step.
        send_slots($urandom_range(1, 3));
      end
    end
  endtask

  // Main sequence: reset, directed events, then random phases over ROM codes.
  initial begin
    logic [63:0] rom_settings [4];
    rom_settings[0] = 64'h0;
    rom_settings[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    rom_settings[2] = {32'($urandom), 32'($urandom)};
    rom_settings[3] = 64'h8000_0000_0000_0001;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed events: range edges of the scratchpad, the unused op, the convert
    // and scratchpad read commands and a reset in the middle of an answer.
    write_rom({32'($urandom), 32'($urandom)});
    gap_chance = 3;
    send_load(4'd0, 8'hFF);
    send_load(4'(PAD_BYTES - 1), 8'h00);
    send_load(4'(PAD_BYTES), 8'h5A);
    send_load(4'd15, 8'hFF);
    send_paced(make_item(OP_UNUSED, 1'b1));
    send_paced(make_item(OP_RESET, 1'b0));
    send_command(CMD_CONVERT);
    send_command(CMD_READ_PAD);
    send_slots(2);
    send_paced(make_item(OP_RESET, 1'b1));

    // Random phases, one per ROM code setting.
    for (int phase = 0; phase < 4; phase++) begin
      write_rom(rom_settings[phase]);
      run_random(TARGET_ITEMS * (phase + 1) / 4, phase == 1 || phase == 3, phase == 2);
    end

    drain();
    $display("Sent %0d transactions over five ROM code settings, with stalls on both sides.",
             items_sent);
    $display("Checked %0d results: %0d ROM reads, %0d scratchpad reads, %0d conversions, %0d resets.",
             responses_checked, rom_reads, pad_reads, conversions, presences);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
